// ----- rtl/tiop_pkg.sv -----
// shared types, protocol constants and reply policy for the telnet option parser
`timescale 1ns / 1ps

package tiop_pkg;

    // telnet command bytes
    localparam logic [7:0] B_IAC  = 8'hFF;
    localparam logic [7:0] B_DONT = 8'hFE;
    localparam logic [7:0] B_DO   = 8'hFD;
    localparam logic [7:0] B_WONT = 8'hFC;
    localparam logic [7:0] B_WILL = 8'hFB;
    localparam logic [7:0] B_SB   = 8'hFA;
    localparam logic [7:0] B_GA   = 8'hF9;
    localparam logic [7:0] B_SE   = 8'hF0;

    // options with their own policy
    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    localparam logic [7:0] OPT_NAWS = 8'd31;

    // window size subnegotiation carries exactly four bytes
    localparam int NAWS_LEN = 4;

    // 2-bit verb codes
    localparam logic [1:0] C_WILL = 2'd0;
    localparam logic [1:0] C_WONT = 2'd1;
    localparam logic [1:0] C_DO   = 2'd2;
    localparam logic [1:0] C_DONT = 2'd3;

    // result kinds
    localparam logic [2:0] K_DATA   = 3'd0;
    localparam logic [2:0] K_REPLY  = 3'd1;
    localparam logic [2:0] K_NAWS   = 3'd2;
    localparam logic [2:0] K_IGN    = 3'd3;
    localparam logic [2:0] K_REPORT = 3'd4;

    // one pending result group; a reply group expands to three words
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_val;
        logic [1:0]  code;
        logic [15:0] cols;
        logic [15:0] rows;
    } t_job;

    // answer code for a received verb on an option
    function automatic logic [1:0] reply_code(input logic [7:0] opt, input logic [1:0] verb);
        logic offer;
        logic [1:0] res;
        offer = (verb == C_WILL) || (verb == C_WONT);
        if (opt == OPT_ECHO) begin
            res = offer ? C_DONT : C_WILL;
        end else if ((opt == OPT_SGA) || (opt == OPT_NAWS)) begin
            res = offer ? C_DO : C_WILL;
        end else begin
            res = offer ? C_DONT : C_WONT;
        end
        return res;
    endfunction

endpackage

// ----- rtl/tiop_out_queue.sv -----
// result queue that expands reply groups into words on the output stream
`timescale 1ns / 1ps

module tiop_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tiop_pkg::t_job     i_job,
    output logic               o_ready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [47:0]        m_axis_tdata,  // byte_value[7:0], cols[23:8], rows[39:24], option_code[41:40]
    output logic [2:0]         m_axis_tuser,  // kind
    output logic               m_axis_tlast
);

    localparam int QDEPTH = 4;
    localparam int PW     = $clog2(QDEPTH);

    tiop_pkg::t_job r_q [QDEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [PW:0]    r_count;
    logic [1:0]     r_word_idx;

    tiop_pkg::t_job head;
    logic [7:0]     out_byte;
    logic [1:0]     out_code;
    logic [15:0]    out_cols;
    logic [15:0]    out_rows;
    logic           out_last;
    logic           word_take;
    logic           pop;

    // room check uses only registered state, so no path from the output ready
    assign o_ready = ((r_count + (PW+1)'(i_push)) <= (PW+1)'(QDEPTH - 2));

    assign head          = r_q[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign word_take     = m_axis_tvalid && m_axis_tready;
    assign pop           = word_take && out_last;

    // word formatting from the head group
    always_comb begin
        out_byte = head.byte_val;
        out_code = 2'd0;
        out_cols = head.cols;
        out_rows = head.rows;
        out_last = 1'b1;
        case (head.kind)
            tiop_pkg::K_REPLY: begin
                out_last = (r_word_idx == 2'd2);
                case (r_word_idx)
                    2'd0:    out_byte = tiop_pkg::B_IAC;
                    2'd1:    out_byte = tiop_pkg::B_WILL + {6'd0, head.code};
                    default: out_byte = head.byte_val;
                endcase
            end
            tiop_pkg::K_REPORT: out_code = head.code;
            default:            out_code = 2'd0;
        endcase
    end

    assign m_axis_tdata = {6'd0, out_code, out_rows, out_cols, out_byte};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = out_last;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_job;
        end
    end

    // pointers, fill count and word position within a group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_word_idx <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr   <= r_rd_ptr + 1'b1;
                r_word_idx <= 2'd0;
            end else if (word_take) begin
                r_word_idx <= r_word_idx + 2'd1;
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(pop);
        end
    end

endmodule

// ----- rtl/telnet_iac_option_parser.sv -----
// top level: telnet receive parser with option negotiation and option store
`timescale 1ns / 1ps

// Input stream: one word per received byte (tuser = 0) or per option query
// (tuser = 1). Output stream: result words; tuser gives the kind, tlast marks
// the final word caused by one input word.
// Plain bytes come out as data, GA is dropped, IAC IAC yields data 255.
// IAC WILL/WONT/DO/DONT opt produces three reply words (IAC, verb, opt) and
// stores the sent verb code in the option memory if opt < NUM_OPTIONS. IAC SB
// opt .. IAC SE gives one window size or ignored-subnegotiation word. A query
// returns one report. The first word of a result passes the parser output
// register, alongside the option memory read, and then the result queue.
// Throughput: one input word per cycle while the queue has room; a reply is
// three output words, so a run of replies is limited by the output port at
// one word per cycle. The input is held off while the four-group result
// queue plus the group entering it hold more than two groups, which keeps a
// slot free for the group still in the parser register.
// Reset empties the queue and returns the parser to looking for IAC; option
// valid bits clear at once, so every option reads as code 0 (WILL) after
// reset with no clearing pass. When the receiver stalls, words stay on the
// output unchanged and input is accepted until that queue limit is reached.

module telnet_iac_option_parser #(
    parameter int SUB_BUF_BYTES = 35,
    parameter int NUM_OPTIONS   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], query_option[13:8]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // byte_value[7:0], cols[23:8], rows[39:24], option_code[41:40]
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(NUM_OPTIONS);
    localparam int LW = $clog2(SUB_BUF_BYTES + 1);

    // parser states
    localparam logic [2:0] PS_CHECK = 3'd0;
    localparam logic [2:0] PS_IAC   = 3'd1;
    localparam logic [2:0] PS_SB    = 3'd2;
    localparam logic [2:0] PS_OPT   = 3'd3;
    localparam logic [2:0] PS_DATA  = 3'd4;
    localparam logic [2:0] PS_SE    = 3'd5;

    logic           accept;
    logic           in_op;
    logic [7:0]     in_byte;
    logic [5:0]     in_q;

    logic [2:0]     r_state, n_state;
    logic [1:0]     r_verb, n_verb;
    logic [7:0]     r_sub_opt, n_sub_opt;
    logic [LW-1:0]  r_sub_len, n_sub_len;
    logic [7:0]     r_sub_bytes [4];
    logic           sb_we;

    logic           n_emit;
    tiop_pkg::t_job n_job;
    logic           r_s1_vld;
    logic           r_s1_query;
    tiop_pkg::t_job r_s1_job;
    tiop_pkg::t_job push_job;
    logic           q_ready;

    logic [1:0]     r_mem [NUM_OPTIONS];
    logic [NUM_OPTIONS-1:0] r_opt_vld;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [1:0]     mem_wd;
    logic [AW-1:0]  mem_ra;
    logic           q_in_range;
    logic [1:0]     r_rd_data;
    logic           r_rd_hit;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = q_ready;
    assign in_op         = s_axis_tuser;
    assign in_byte       = s_axis_tdata[7:0];
    assign in_q          = s_axis_tdata[13:8];

    // byte parser: next state, buffered subnegotiation bytes, result group
    always_comb begin
        n_state   = r_state;
        n_verb    = r_verb;
        n_sub_opt = r_sub_opt;
        n_sub_len = r_sub_len;
        sb_we     = 1'b0;
        mem_we    = 1'b0;
        mem_wd    = tiop_pkg::reply_code(in_byte, r_verb);
        mem_wa    = AW'(in_byte);
        n_emit    = 1'b0;
        n_job     = '0;
        if (accept) begin
            if (in_op) begin
                n_emit         = 1'b1;
                n_job.kind     = tiop_pkg::K_REPORT;
                n_job.byte_val = {2'd0, in_q};
            end else begin
                case (r_state)
                    PS_IAC: begin
                        n_state = PS_CHECK;
                        if (in_byte == tiop_pkg::B_SB) begin
                            n_state = PS_SB;
                        end else if ((in_byte >= tiop_pkg::B_WILL) &&
                                     (in_byte <= tiop_pkg::B_DONT)) begin
                            n_verb  = 2'(in_byte - tiop_pkg::B_WILL);
                            n_state = PS_OPT;
                        end else if (in_byte == tiop_pkg::B_IAC) begin
                            n_emit         = 1'b1;
                            n_job.kind     = tiop_pkg::K_DATA;
                            n_job.byte_val = tiop_pkg::B_IAC;
                        end
                    end
                    PS_SB: begin
                        n_sub_opt = in_byte;
                        n_sub_len = '0;
                        n_state   = PS_DATA;
                    end
                    PS_OPT: begin
                        n_state        = PS_CHECK;
                        mem_we         = ({1'b0, in_byte} < 9'(NUM_OPTIONS));
                        n_emit         = 1'b1;
                        n_job.kind     = tiop_pkg::K_REPLY;
                        n_job.byte_val = in_byte;
                        n_job.code     = mem_wd;
                    end
                    PS_DATA: begin
                        if (in_byte == tiop_pkg::B_IAC) begin
                            n_state = PS_SE;
                        end else begin
                            sb_we = (r_sub_len < LW'(tiop_pkg::NAWS_LEN));
                            if (r_sub_len < LW'(SUB_BUF_BYTES)) begin
                                n_sub_len = r_sub_len + 1'b1;
                            end
                        end
                    end
                    PS_SE: begin
                        if (in_byte == tiop_pkg::B_SE) begin
                            n_state        = PS_CHECK;
                            n_emit         = 1'b1;
                            n_job.byte_val = r_sub_opt;
                            if ((r_sub_opt == tiop_pkg::OPT_NAWS) &&
                                (r_sub_len == LW'(tiop_pkg::NAWS_LEN))) begin
                                n_job.kind = tiop_pkg::K_NAWS;
                                n_job.cols = {r_sub_bytes[0], r_sub_bytes[1]};
                                n_job.rows = {r_sub_bytes[2], r_sub_bytes[3]};
                            end else begin
                                n_job.kind = tiop_pkg::K_IGN;
                            end
                        end
                    end
                    default: begin
                        n_state = PS_CHECK;
                        if (in_byte == tiop_pkg::B_IAC) begin
                            n_state = PS_IAC;
                        end else if (in_byte != tiop_pkg::B_GA) begin
                            n_emit         = 1'b1;
                            n_job.kind     = tiop_pkg::K_DATA;
                            n_job.byte_val = in_byte;
                        end
                    end
                endcase
            end
        end
    end

    // parser control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= PS_CHECK;
            r_verb    <= 2'd0;
            r_sub_opt <= 8'd0;
            r_sub_len <= '0;
        end else begin
            r_state   <= n_state;
            r_verb    <= n_verb;
            r_sub_opt <= n_sub_opt;
            r_sub_len <= n_sub_len;
        end
    end

    // first four subnegotiation bytes
    always_ff @(posedge i_clk) begin
        if (sb_we) begin
            r_sub_bytes[r_sub_len[1:0]] <= in_byte;
        end
    end

    // option memory write; a query in the next cycle already sees the new entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt_vld <= '0;
        end else if (mem_we) begin
            r_opt_vld[mem_wa] <= 1'b1;
        end
    end

    // option memory read for queries, registered
    assign mem_ra     = AW'(in_q);
    assign q_in_range = ({3'd0, in_q} < 9'(NUM_OPTIONS));

    always_ff @(posedge i_clk) begin
        if (accept && in_op) begin
            r_rd_data <= r_mem[mem_ra];
            r_rd_hit  <= q_in_range && r_opt_vld[mem_ra];
        end
    end

    // parser output register, aligned with the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_s1_job   <= n_job;
            r_s1_query <= in_op;
        end
    end

    // merge the stored code into a report
    always_comb begin
        push_job = r_s1_job;
        if (r_s1_query) begin
            push_job.code = r_rd_hit ? r_rd_data : 2'd0;
        end
    end

    tiop_out_queue u_out_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (r_s1_vld),
        .i_job         (push_job),
        .o_ready       (q_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- rtl/tiop_checker.sv -----
// port-level checks on the telnet option parser, bound to the top level
`timescale 1ns / 1ps

module tiop_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // queue is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // only reply groups span several words
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != tiop_pkg::K_REPLY)) |-> m_axis_tlast)
        else $error("non-reply word without last");

    // a reply group continues with reply words
    a_reply_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && (m_axis_tuser == tiop_pkg::K_REPLY) &&
         !m_axis_tlast) |=> (m_axis_tvalid && (m_axis_tuser == tiop_pkg::K_REPLY)))
        else $error("reply group broken");

    // the option code field is only used by reports
    a_code_report_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != tiop_pkg::K_REPORT)) |->
        (m_axis_tdata[41:40] == 2'd0))
        else $error("option code outside report");

endmodule

bind telnet_iac_option_parser tiop_checker u_tiop_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
